>>> rtl/button_hold_gesture_classifier_assert.svh
// Assertion macros shared by the checker.
`ifndef BUTTON_HOLD_GESTURE_CLASSIFIER_ASSERT_SVH
`define BUTTON_HOLD_GESTURE_CLASSIFIER_ASSERT_SVH

// Checked only out of reset.
`define BHG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define BHG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/bhg_pkg.sv
package bhg_pkg;

    typedef enum logic [2:0] {
        PH_BOOT     = 3'd0,
        PH_RCOUNT   = 3'd1,
        PH_RARMED   = 3'd2,
        PH_IDLE     = 3'd3,
        PH_DEBOUNCE = 3'd4,
        PH_HOLD     = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        G_NONE    = 3'd0,
        G_INSPECT = 3'd1,
        G_REFILL  = 3'd2,
        G_RESTORE = 3'd3,
        G_STUCK   = 3'd4,
        G_RCANCEL = 3'd5
    } gesture_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REFILL_HOLD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STUCK          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_STABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RESTORE_HOLD   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RESTORE_BLINK  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RESTORE_STUCK  = 3'd7;

    localparam logic [7:0]  DEF_DEBOUNCE       = 8'd30;
    localparam logic [15:0] DEF_REFILL_HOLD    = 16'd1000;
    localparam logic [15:0] DEF_STUCK          = 16'd6000;
    localparam logic [7:0]  DEF_RELEASE_STABLE = 8'd50;
    localparam logic [7:0]  DEF_BLINK_HALF     = 8'd100;
    localparam logic [15:0] DEF_RESTORE_HOLD   = 16'd3000;
    localparam logic [7:0]  DEF_RESTORE_BLINK  = 8'd150;
    localparam logic [15:0] DEF_RESTORE_STUCK  = 16'd10000;

    typedef struct packed {
        logic [7:0]  debounce_ticks;
        logic [15:0] refill_hold_ticks;
        logic [15:0] stuck_ticks;
        logic [7:0]  release_stable_ticks;
        logic [7:0]  blink_half_ticks;
        logic [15:0] restore_hold_ticks;
        logic [7:0]  restore_blink_half_ticks;
        logic [15:0] restore_stuck_ticks;
    } bhg_cfg_t;

endpackage

>>> rtl/bhg_cfg.sv
module bhg_cfg
    import bhg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output bhg_cfg_t              cfg
);

    bhg_cfg_t cfg_reg;
    bhg_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                REG_DEBOUNCE:       cfg_next.debounce_ticks           = wr_data[7:0];
                REG_REFILL_HOLD:    cfg_next.refill_hold_ticks        = wr_data;
                REG_STUCK:          cfg_next.stuck_ticks              = wr_data;
                REG_RELEASE_STABLE: cfg_next.release_stable_ticks     = wr_data[7:0];
                REG_BLINK_HALF:     cfg_next.blink_half_ticks         = wr_data[7:0];
                REG_RESTORE_HOLD:   cfg_next.restore_hold_ticks       = wr_data;
                REG_RESTORE_BLINK:  cfg_next.restore_blink_half_ticks = wr_data[7:0];
                REG_RESTORE_STUCK:  cfg_next.restore_stuck_ticks      = wr_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks           <= DEF_DEBOUNCE;
            cfg_reg.refill_hold_ticks        <= DEF_REFILL_HOLD;
            cfg_reg.stuck_ticks              <= DEF_STUCK;
            cfg_reg.release_stable_ticks     <= DEF_RELEASE_STABLE;
            cfg_reg.blink_half_ticks         <= DEF_BLINK_HALF;
            cfg_reg.restore_hold_ticks       <= DEF_RESTORE_HOLD;
            cfg_reg.restore_blink_half_ticks <= DEF_RESTORE_BLINK;
            cfg_reg.restore_stuck_ticks      <= DEF_RESTORE_STUCK;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/bhg_step.sv
module bhg_step
    import bhg_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  bhg_cfg_t  cfg,
    input  logic      step_en,
    input  logic      pressed,
    output gesture_t  gesture,
    output logic      led_on
);

    phase_t      phase_reg, phase_next;
    logic [15:0] hold_reg, hold_next;
    logic [7:0]  rel_reg, rel_next;
    logic [7:0]  blink_reg, blink_next;
    logic        led_reg, led_next;
    logic        commit_reg, commit_next;

    logic [15:0] hold_inc;
    logic [7:0]  rel_inc;
    logic [7:0]  blink_inc;
    logic        rel_done;

    assign hold_inc  = (hold_reg == 16'hFFFF) ? hold_reg : hold_reg + 16'd1;
    assign rel_inc   = (rel_reg == 8'hFF) ? rel_reg : rel_reg + 8'd1;
    assign blink_inc = (blink_reg == 8'hFF) ? blink_reg : blink_reg + 8'd1;

    always_comb begin
        phase_next  = phase_reg;
        hold_next   = hold_reg;
        rel_next    = rel_reg;
        blink_next  = blink_reg;
        led_next    = led_reg;
        commit_next = commit_reg;
        gesture     = G_NONE;
        rel_done    = 1'b0;

        if (phase_reg == PH_RARMED || phase_reg == PH_HOLD) begin
            if (pressed) begin
                rel_next = 8'd0;
            end else begin
                rel_next = rel_inc;
                rel_done = (rel_inc >= cfg.release_stable_ticks);
            end
        end

        unique case (phase_reg)
            PH_BOOT: begin
                if (pressed) begin
                    phase_next = PH_RCOUNT;
                    hold_next  = 16'd0;
                    blink_next = 8'd0;
                    led_next   = 1'b0;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
            PH_RCOUNT: begin
                if (!pressed) begin
                    phase_next = PH_IDLE;
                end else if (hold_inc >= cfg.restore_hold_ticks) begin
                    phase_next = PH_RARMED;
                    led_next   = 1'b1;
                    hold_next  = 16'd0;
                    rel_next   = 8'd0;
                end else begin
                    hold_next = hold_inc;
                    if (blink_inc >= cfg.restore_blink_half_ticks) begin
                        led_next   = !led_reg;
                        blink_next = 8'd0;
                    end else begin
                        blink_next = blink_inc;
                    end
                end
            end
            PH_RARMED: begin
                hold_next = hold_inc;
                if (rel_done) begin
                    gesture    = G_RESTORE;
                    phase_next = PH_IDLE;
                end else if (hold_inc > cfg.restore_stuck_ticks) begin
                    gesture    = G_RCANCEL;
                    phase_next = PH_IDLE;
                end
            end
            PH_DEBOUNCE: begin
                hold_next = hold_inc;
                if (hold_inc >= {8'd0, cfg.debounce_ticks}) begin
                    if (pressed) begin
                        phase_next  = PH_HOLD;
                        hold_next   = 16'd0;
                        rel_next    = 8'd0;
                        commit_next = 1'b0;
                        blink_next  = 8'd0;
                        led_next    = 1'b0;
                    end else begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_HOLD: begin
                hold_next = hold_inc;
                if (rel_done) begin
                    gesture    = commit_reg ? G_REFILL : G_INSPECT;
                    phase_next = PH_IDLE;
                end else if (hold_inc > cfg.stuck_ticks) begin
                    gesture    = G_STUCK;
                    phase_next = PH_IDLE;
                end else if (commit_reg) begin
                    led_next = 1'b1;
                end else if (hold_inc >= cfg.refill_hold_ticks) begin
                    commit_next = 1'b1;
                    led_next    = 1'b1;
                end else if (blink_inc >= cfg.blink_half_ticks) begin
                    led_next   = !led_reg;
                    blink_next = 8'd0;
                end else begin
                    blink_next = blink_inc;
                end
            end
            default: begin
                phase_next = pressed ? PH_DEBOUNCE : PH_IDLE;
            end
        endcase

        if (phase_next == PH_IDLE || (phase_next == PH_DEBOUNCE && phase_reg != PH_DEBOUNCE)) begin
            hold_next   = 16'd0;
            rel_next    = 8'd0;
            blink_next  = 8'd0;
            led_next    = 1'b0;
            commit_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_BOOT;
            hold_reg   <= 16'd0;
            rel_reg    <= 8'd0;
            blink_reg  <= 8'd0;
            led_reg    <= 1'b0;
            commit_reg <= 1'b0;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            hold_reg   <= hold_next;
            rel_reg    <= rel_next;
            blink_reg  <= blink_next;
            led_reg    <= led_next;
            commit_reg <= commit_next;
        end
    end

    assign led_on = led_next;

endmodule

>>> rtl/button_hold_gesture_classifier.sv
// Button hold gesture classifier.
// Slave stream: one beat per tick, s_tdata[0] is the sampled button level.
// Master stream: one beat per accepted tick, m_tdata carries the gesture
// code (0 none, 1 inspect, 2 refill, 3 restore, 4 stuck abandoned,
// 5 restore cancelled) and the LED drive after that tick.
// Configuration: cfg_index selects one of eight timing registers, cfg_data
// holds the value; each write lands in its timing register, cfg_ready is always high.
// Pipeline: the slave beat is held in the input register and its result
// in the result register.
// Throughput: one beat per cycle unless m_tready stalls the result; the tick update
// is one compare and increment layer on the 16-bit hold counter.
// Reset: all timing registers take their defaults, the classifier starts in
// the boot check and both stream stages empty.
// Stall: the result register holds while m_tready is low; the input register
// still takes one more beat, then s_tready drops until the result moves on.
module button_hold_gesture_classifier
    import bhg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [0] button_pressed, [7:1] zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [2:0] gesture, [3] led_on, [7:4] zero
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    bhg_cfg_t cfg;
    logic     in_valid_reg;
    logic     in_bit_reg;
    logic     out_valid_reg;
    gesture_t out_gesture_reg;
    logic     out_led_reg;
    logic     advance;
    gesture_t step_gesture;
    logic     step_led;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;

    bhg_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    bhg_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step_en (advance),
        .pressed (in_bit_reg),
        .gesture (step_gesture),
        .led_on  (step_led)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_bit_reg <= s_tdata[0];
        end
        if (advance) begin
            out_gesture_reg <= step_gesture;
            out_led_reg     <= step_led;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_led_reg, out_gesture_reg};

endmodule

>>> rtl/bhg_checker.sv
`include "button_hold_gesture_classifier_assert.svh"

module bhg_checker
    import bhg_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [7:0]            s_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [7:0]            m_tdata,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    logic m_stall;

    assign m_stall = m_tvalid && !m_tready;

    `BHG_ASSERT(a_m_hold, m_stall |=> m_tvalid && $stable(m_tdata), "master beat moved")
    `BHG_ASSERT(a_gesture_range, m_tvalid |-> m_tdata[2:0] <= G_RCANCEL && m_tdata[7:4] == 4'd0, "bad beat")
    `BHG_ASSERT(a_gesture_led_off, m_tvalid && m_tdata[2:0] != G_NONE |-> !m_tdata[3], "LED lit")
    `BHG_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "master beat valid after reset")

endmodule

bind button_hold_gesture_classifier bhg_checker u_bhg_checker (.*);

>>> bench/button_hold_gesture_classifier_tb.sv
module button_hold_gesture_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bhg_pkg::*;

    localparam int unsigned IDLE_PCT       = 27;
    localparam int unsigned STALL_LEN      = 300;
    localparam int unsigned WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        gesture_t gesture;
        logic     led_on;
    } tick_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [7:0]            s_tdata   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_DEBOUNCE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire  [7:0]            m_tdata;
    wire                   cfg_ready;

    // classifier state as predicted
    phase_t      ph         = PH_BOOT;
    int unsigned hold_cnt   = 0;
    int unsigned rel_cnt    = 0;
    int unsigned blink_cnt  = 0;
    bit          led_lvl    = 1'b0;
    bit          refill_set = 1'b0;
    int unsigned reg_val [8] = '{DEF_DEBOUNCE, DEF_REFILL_HOLD, DEF_STUCK, DEF_RELEASE_STABLE,
                                 DEF_BLINK_HALF, DEF_RESTORE_HOLD, DEF_RESTORE_BLINK,
                                 DEF_RESTORE_STUCK};

    bit           pending_ticks [$];
    tick_result_t predicted_gestures [$];
    int unsigned  ticks_queued = 0;
    int unsigned  out_beats    = 0;
    int unsigned  stalls_taken = 0;
    int unsigned  hold_off     = 0;
    int unsigned  quiet_cycles = 0;
    int unsigned  cycle_no     = 0;
    int           mismatches   = 0;

    button_hold_gesture_classifier dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [0] button_pressed, [7:1] zero
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [2:0] gesture, [3] led_on, [7:4] zero
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic bit calm();
        return (cycle_no % 1200) >= 800;
    endfunction

    function automatic void go_idle();
        ph         = PH_IDLE;
        led_lvl    = 1'b0;
        hold_cnt   = 0;
        rel_cnt    = 0;
        blink_cnt  = 0;
        refill_set = 1'b0;
    endfunction

    function automatic void bump_hold();
        if (hold_cnt < 65535) hold_cnt++;
    endfunction

    function automatic void blink_step(input int unsigned half);
        if (blink_cnt < 255) blink_cnt++;
        if (blink_cnt >= half) begin
            led_lvl   = !led_lvl;
            blink_cnt = 0;
        end
    endfunction

    function automatic bit released(input bit pressed);
        if (pressed) begin
            rel_cnt = 0;
            return 1'b0;
        end
        if (rel_cnt < 255) rel_cnt++;
        return rel_cnt >= reg_val[REG_RELEASE_STABLE];
    endfunction

    function automatic tick_result_t classify_tick(input bit pressed);
        gesture_t g;
        g = G_NONE;
        case (ph)
            PH_BOOT: begin
                if (pressed) begin
                    ph        = PH_RCOUNT;
                    hold_cnt  = 0;
                    blink_cnt = 0;
                    led_lvl   = 1'b0;
                end else begin
                    go_idle();
                end
            end
            PH_RCOUNT: begin
                if (!pressed) begin
                    go_idle();
                end else begin
                    bump_hold();
                    if (hold_cnt >= reg_val[REG_RESTORE_HOLD]) begin
                        ph       = PH_RARMED;
                        led_lvl  = 1'b1;
                        hold_cnt = 0;
                        rel_cnt  = 0;
                    end else begin
                        blink_step(reg_val[REG_RESTORE_BLINK]);
                    end
                end
            end
            PH_RARMED: begin
                if (released(pressed)) begin
                    g = G_RESTORE;
                    go_idle();
                end else begin
                    bump_hold();
                    if (hold_cnt > reg_val[REG_RESTORE_STUCK]) begin
                        g = G_RCANCEL;
                        go_idle();
                    end
                end
            end
            PH_DEBOUNCE: begin
                bump_hold();
                if (hold_cnt >= reg_val[REG_DEBOUNCE]) begin
                    if (pressed) begin
                        ph         = PH_HOLD;
                        hold_cnt   = 0;
                        rel_cnt    = 0;
                        refill_set = 1'b0;
                        blink_cnt  = 0;
                        led_lvl    = 1'b0;
                    end else begin
                        go_idle();
                    end
                end
            end
            PH_HOLD: begin
                if (released(pressed)) begin
                    g = refill_set ? G_REFILL : G_INSPECT;
                    go_idle();
                end else begin
                    bump_hold();
                    if (hold_cnt > reg_val[REG_STUCK]) begin
                        g = G_STUCK;
                        go_idle();
                    end else if (!refill_set) begin
                        if (hold_cnt >= reg_val[REG_REFILL_HOLD]) begin
                            refill_set = 1'b1;
                            led_lvl    = 1'b1;
                        end else begin
                            blink_step(reg_val[REG_BLINK_HALF]);
                        end
                    end
                end
            end
            default: begin
                if (ph != PH_IDLE) go_idle();
                if (pressed) begin
                    ph       = PH_DEBOUNCE;
                    hold_cnt = 0;
                end
            end
        endcase
        return '{gesture: g, led_on: led_lvl};
    endfunction

    // driver: predict on each accepted beat, then offer the next tick
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DEBOUNCE, REG_RELEASE_STABLE, REG_BLINK_HALF, REG_RESTORE_BLINK: begin
                        reg_val[cfg_index] = cfg_data[7:0];
                    end
                    default: reg_val[cfg_index] = cfg_data;
                endcase
            end
            if (s_tvalid && s_tready) predicted_gestures.push_back(classify_tick(s_tdata[0]));
            if (!s_tvalid || s_tready) begin
                if (pending_ticks.size() != 0 && (calm() || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    s_tdata  <= {7'b0, pending_ticks.pop_front()};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus two long hold-offs while ticks are still waiting
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_off <= 0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else if (pending_ticks.size() >= 20 &&
                     ((stalls_taken == 0 && out_beats >= 300) ||
                      (stalls_taken == 1 && out_beats >= 550))) begin
            stalls_taken <= stalls_taken + 1;
            hold_off     <= STALL_LEN;
            m_tready     <= 1'b0;
        end else begin
            m_tready <= calm() || $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    always @(posedge aclk) begin
        tick_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            out_beats <= out_beats + 1;
            if (predicted_gestures.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: result beat %0d with nothing predicted, m_tdata %h",
                             $time, out_beats, m_tdata);
                mismatches++;
            end else begin
                want = predicted_gestures.pop_front();
                if (m_tdata[2:0] !== want.gesture || m_tdata[3] !== want.led_on) begin
                    if (mismatches < 10)
                        $display("%0t: beat %0d expected gesture %0d led %0d, got gesture %0d led %0d",
                                 $time, out_beats, want.gesture, want.led_on,
                                 m_tdata[2:0], m_tdata[3]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("button_hold_gesture_classifier_tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_run(input bit level, input int unsigned n);
        repeat (n) pending_ticks.push_back(level);
        ticks_queued += n;
    endtask

    task automatic load_regs(input int unsigned vals [8]);
        for (int i = 0; i < 8; i++) begin
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i][CFG_DATA_W-1:0];
            cfg_valid <= 1'b1;
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do @(posedge aclk);
        while (pending_ticks.size() != 0 || s_tvalid || predicted_gestures.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // mostly whole presses sized against the current timing, the rest noise
    task automatic random_ticks(input int unsigned budget);
        int unsigned start, deb, rel, ones;
        start = ticks_queued;
        deb   = (reg_val[REG_DEBOUNCE] == 0) ? 1 : reg_val[REG_DEBOUNCE];
        rel   = reg_val[REG_RELEASE_STABLE];
        while (ticks_queued - start < budget) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    push_run(1'b0, $urandom_range(0, 3));
                    case ($urandom_range(0, 3))
                        0: ones = $urandom_range(1, deb);
                        1: ones = 1 + deb + $urandom_range(0, reg_val[REG_REFILL_HOLD]);
                        2: ones = 1 + deb + $urandom_range(reg_val[REG_REFILL_HOLD],
                                                           reg_val[REG_STUCK]);
                        default: ones = 1 + deb + reg_val[REG_STUCK] + $urandom_range(1, 3);
                    endcase
                    push_run(1'b1, (ones > 400) ? 400 : ones);
                    if (rel > 1 && $urandom_range(0, 2) == 0) begin
                        push_run(1'b0, $urandom_range(1, rel - 1));
                        push_run(1'b1, $urandom_range(1, 3));
                    end
                    push_run(1'b0, rel + $urandom_range(0, 3));
                end
                6, 7, 8: repeat ($urandom_range(1, 12)) push_run(1'($urandom_range(0, 1)), 1);
                default: push_run(1'b0, $urandom_range(1, 8));
            endcase
        end
        push_run(1'b0, 10);
    endtask

    initial begin
        int unsigned v [8];
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        v[REG_DEBOUNCE]       = 2;
        v[REG_REFILL_HOLD]    = 6;
        v[REG_STUCK]          = 10;
        v[REG_RELEASE_STABLE] = 2;
        v[REG_BLINK_HALF]     = 1;
        v[REG_RESTORE_HOLD]   = 4;
        v[REG_RESTORE_BLINK]  = 1;
        v[REG_RESTORE_STUCK]  = 6;
        load_regs(v);
        // the boot check happens once per reset: take one of its three outcomes
        case ($urandom_range(0, 2))
            0: begin
                push_run(1'b1, 7);
                push_run(1'b0, 1);
                push_run(1'b1, 1);
                push_run(1'b0, 3);
            end
            1: begin
                push_run(1'b1, 14);
                push_run(1'b0, 3);
            end
            default: begin
                push_run(1'b1, 3);
                push_run(1'b0, 2);
            end
        endcase
        push_run(1'b1, 5);
        push_run(1'b0, 2);
        push_run(1'b1, 10);
        push_run(1'b0, 3);
        drain();

        foreach (v[i]) v[i] = 0;
        load_regs(v);
        random_ticks(100);
        drain();

        foreach (v[i]) v[i] = 1;
        load_regs(v);
        random_ticks(100);
        drain();

        repeat (4) begin
            v[REG_DEBOUNCE]       = $urandom_range(0, 6);
            v[REG_REFILL_HOLD]    = $urandom_range(0, 24);
            v[REG_STUCK]          = $urandom_range(0, 40);
            v[REG_RELEASE_STABLE] = $urandom_range(0, 6);
            v[REG_BLINK_HALF]     = $urandom_range(0, 4);
            v[REG_RESTORE_HOLD]   = $urandom_range(0, 65535);
            v[REG_RESTORE_BLINK]  = $urandom_range(0, 255);
            v[REG_RESTORE_STUCK]  = $urandom_range(0, 65535);
            load_regs(v);
            random_ticks(80);
            drain();
        end

        // stuck limit at the top of the counter range: never abandoned, reports refill
        v[REG_DEBOUNCE]       = 2;
        v[REG_REFILL_HOLD]    = 10;
        v[REG_STUCK]          = 65535;
        v[REG_RELEASE_STABLE] = 3;
        v[REG_BLINK_HALF]     = 2;
        v[REG_RESTORE_HOLD]   = 65535;
        v[REG_RESTORE_BLINK]  = 255;
        v[REG_RESTORE_STUCK]  = 65535;
        load_regs(v);
        push_run(1'b1, 1 + 2 + 40);
        push_run(1'b0, 5);
        drain();
        repeat (10) @(posedge aclk);

        if (mismatches == 0 && predicted_gestures.size() == 0) begin
            $display("button_hold_gesture_classifier_tb: clean");
        end else begin
            $display("button_hold_gesture_classifier_tb: errors");
        end
        $finish;
    end

endmodule
